// ----- design/misd_pkg.sv -----
// shared types and constants for the minimum-image distance block
// no dependencies
`timescale 1ns / 1ps

package misd_pkg;

    // field widths fixed by the interface
    localparam int FIELD_W   = 24;
    localparam int LEN_W     = 24;
    localparam int INV_W     = 32;
    localparam int DIST_W    = 50;
    localparam int SHIFT_W   = 8;
    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int AXES      = 3;

    // default build parameters
    localparam int DEF_COORD_BITS = 24;
    localparam int DEF_MAX_PAIRS  = 65536;

    // queue between front and back, power of two
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // saturation limits
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X = 3'd0,
        REG_BOX_Y = 3'd1,
        REG_BOX_Z = 3'd2,
        REG_INV_X = 3'd3,
        REG_INV_Y = 3'd4,
        REG_INV_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [AXES-1:0][LEN_W-1:0] box_len;
        logic [AXES-1:0][INV_W-1:0] inv_len;
    } t_cfg;

    // one classified pair handed from front to back
    typedef struct packed {
        logic [DIST_W-1:0]              dist_sq;
        logic [AXES-1:0][SHIFT_W-1:0]   shift;
        logic                           last;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0]              dist_sq;
        logic [AXES-1:0][SHIFT_W-1:0]   shift;
        logic [INDEX_W-1:0]             index;
        logic                           is_last;
    } t_result;

endpackage

// ----- design/min_image_sq_distance_argmin_shift.sv -----
// minimum-image squared distance with running arg-min: one pair per cycle
// while o_full is low; a result reaches the ports through the pipeline
// (six front stages bounded by the 57-bit reciprocal product and the squares,
// one queue slot, one result register); throughput one request per cycle
// unless o_full; synchronous active-low i_rst_n empties pipeline, queue and
// result register, sets edge lengths to 1, reciprocals to 0, restarts search
`timescale 1ns / 1ps

module min_image_sq_distance_argmin_shift import misd_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_PAIRS  = DEF_MAX_PAIRS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,

    // pair input, queue style
    input  logic                        i_push,
    output logic                        o_full,
    input  logic signed [FIELD_W-1:0]   i_a_x,
    input  logic signed [FIELD_W-1:0]   i_a_y,
    input  logic signed [FIELD_W-1:0]   i_a_z,
    input  logic signed [FIELD_W-1:0]   i_b_x,
    input  logic signed [FIELD_W-1:0]   i_b_y,
    input  logic signed [FIELD_W-1:0]   i_b_z,
    input  logic                        i_last_pair,

    // result output, queue style
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [DIST_W-1:0]           o_dist_sq,
    output logic signed [SHIFT_W-1:0]   o_min_shift_x,
    output logic signed [SHIFT_W-1:0]   o_min_shift_y,
    output logic signed [SHIFT_W-1:0]   o_min_shift_z,
    output logic [INDEX_W-1:0]          o_min_index,
    output logic                        o_is_last
);

    t_cfg       r_cfg;
    logic       cfg_wr;

    logic       q_push;
    t_item      q_in;
    logic       q_valid;
    t_item      q_out;
    logic       q_pop;

    logic       res_valid;
    t_result    res;

    // configuration registers, always ready; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_len <= {AXES{LEN_W'(1)}};
            r_cfg.inv_len <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_BOX_X: r_cfg.box_len[0] <= i_cfg_data[LEN_W-1:0];
                REG_BOX_Y: r_cfg.box_len[1] <= i_cfg_data[LEN_W-1:0];
                REG_BOX_Z: r_cfg.box_len[2] <= i_cfg_data[LEN_W-1:0];
                REG_INV_X: r_cfg.inv_len[0] <= i_cfg_data[INV_W-1:0];
                REG_INV_Y: r_cfg.inv_len[1] <= i_cfg_data[INV_W-1:0];
                REG_INV_Z: r_cfg.inv_len[2] <= i_cfg_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: difference, rounded shift, wrapped square per axis, clamped sum;
    // it holds one credit per queue entry so its pipeline never stalls
    misd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_a        ({i_a_z, i_a_y, i_a_x}),
        .i_b        ({i_b_z, i_b_y, i_b_x}),
        .i_last     (i_last_pair),
        .i_q_pop    (q_pop),
        .o_q_push   (q_push),
        .o_q_item   (q_in)
    );

    // decouples the fixed-latency front from the result side
    misd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (q_in),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_item     (q_out)
    );

    // back: running minimum, pair ordinal and the result register
    misd_back #(
        .MAX_PAIRS  (MAX_PAIRS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_out),
        .o_take     (q_pop),
        .o_valid    (res_valid),
        .i_pop      (i_pop),
        .o_res      (res)
    );

    assign o_empty       = !res_valid;
    assign o_dist_sq     = res.dist_sq;
    assign o_min_shift_x = $signed(res.shift[0]);
    assign o_min_shift_y = $signed(res.shift[1]);
    assign o_min_shift_z = $signed(res.shift[2]);
    assign o_min_index   = res.index;
    assign o_is_last     = res.is_last;

endmodule

// ----- design/misd_front.sv -----
// front pipeline: per-axis difference, rounded box shift and squared distance
// depends on misd_pkg
`timescale 1ns / 1ps

module misd_front import misd_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [AXES-1:0][FIELD_W-1:0]    i_a,
    input  logic [AXES-1:0][FIELD_W-1:0]    i_b,
    input  logic                            i_last,
    input  logic                            i_q_pop,
    output logic                            o_q_push,
    output t_item                           o_q_item
);

    localparam int DW    = COORD_BITS + 1;     // signed difference
    localparam int PW    = DW + INV_W;         // magnitude times reciprocal
    localparam int RW    = DW + 1;             // rounded quotient
    localparam int SLW   = SHIFT_W + LEN_W + 1; // shift times edge
    localparam int AW    = SLW + 1;            // adjusted difference
    localparam int MW    = DIST_W / 2;         // in-range magnitude
    localparam int SUMW  = DIST_W + 2;

    logic                    accept;
    logic [QCNT_W-1:0]       r_used;
    logic [QCNT_W-1:0]       n_used;
    logic [6:1]              r_v;
    logic [6:1]              r_last;

    logic [AXES-1:0][DIST_W-1:0]  sq6;
    logic [AXES-1:0]              ovf6;
    logic [AXES-1:0][SHIFT_W-1:0] sh6;
    logic [SUMW-1:0]              sum;

    // credit counter covers items in the pipeline and in the queue
    assign o_full = (r_used == QCNT_W'(QUEUE_DEPTH));
    assign accept = i_push && !o_full;

    always_comb begin
        n_used = r_used;
        if (accept && !i_q_pop) begin
            n_used = r_used + 1'b1;
        end else if (!accept && i_q_pop) begin
            n_used = r_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_v    <= '0;
        end else begin
            r_used <= n_used;
            r_v    <= {r_v[5:1], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[5:1], i_last};
    end

    for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
        logic signed [DW-1:0]    a_s;
        logic signed [DW-1:0]    b_s;
        logic signed [DW-1:0]    r_d1, r_d2, r_d3, r_d4;
        logic [DW-1:0]           mag;
        logic [PW-1:0]           r_p2;
        logic [PW:0]             p_rnd;
        logic [RW-1:0]           rq;
        logic [SHIFT_W-1:0]      sh;
        logic [SHIFT_W-1:0]      r_sh3, r_sh4, r_sh5, r_sh6;
        logic signed [SLW-1:0]   shl;
        logic signed [SLW-1:0]   r_shl4;
        logic signed [AW-1:0]    adj;
        logic [AW-1:0]           am;
        logic [MW-1:0]           r_am5;
        logic                    r_ovf5, r_ovf6;
        logic [DIST_W-1:0]       r_sq6;
        logic                    d_pos;
        logic                    d_neg;

        // stage 1: sign-extended difference
        assign a_s = $signed({i_a[ax][COORD_BITS-1], i_a[ax][COORD_BITS-1:0]});
        assign b_s = $signed({i_b[ax][COORD_BITS-1], i_b[ax][COORD_BITS-1:0]});

        always_ff @(posedge i_clk) begin
            r_d1 <= b_s - a_s;
        end

        // stage 2: |d| times reciprocal
        assign mag = r_d1[DW-1] ? DW'(-r_d1) : DW'(r_d1);

        always_ff @(posedge i_clk) begin
            r_p2 <= PW'(mag * i_cfg.inv_len[ax]);
            r_d2 <= r_d1;
        end

        // stage 3: round half away from zero, negate, saturate
        assign p_rnd = {1'b0, r_p2} + (PW+1)'(64'd1 << 31);
        assign rq    = p_rnd[PW:INV_W];
        assign d_neg = r_d2[DW-1];
        assign d_pos = !r_d2[DW-1] && (r_d2 != '0);

        always_comb begin
            sh = '0;
            if (d_pos) begin
                sh = (rq > RW'(128)) ? 8'h80 : SHIFT_W'(-rq[SHIFT_W-1:0]);
            end else if (d_neg) begin
                sh = (rq > RW'(127)) ? 8'h7f : rq[SHIFT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sh3 <= sh;
            r_d3  <= r_d2;
        end

        // stage 4: shift times edge length
        assign shl = $signed(r_sh3) * $signed({1'b0, i_cfg.box_len[ax]});

        always_ff @(posedge i_clk) begin
            r_shl4 <= shl;
            r_d4   <= r_d3;
            r_sh4  <= r_sh3;
        end

        // stage 5: wrapped difference, magnitude and range check
        assign adj = $signed({{(AW-DW){r_d4[DW-1]}}, r_d4}) + $signed({r_shl4[SLW-1], r_shl4});
        assign am  = adj[AW-1] ? AW'(-adj) : AW'(adj);

        always_ff @(posedge i_clk) begin
            r_am5  <= am[MW-1:0];
            r_ovf5 <= |am[AW-1:MW];
            r_sh5  <= r_sh4;
        end

        // stage 6: square
        always_ff @(posedge i_clk) begin
            r_sq6  <= r_am5 * r_am5;
            r_ovf6 <= r_ovf5;
            r_sh6  <= r_sh5;
        end

        assign sq6[ax]  = r_sq6;
        assign ovf6[ax] = r_ovf6;
        assign sh6[ax]  = r_sh6;
    end

    // sum of the three axes, clamped
    assign sum = SUMW'(sq6[0]) + SUMW'(sq6[1]) + SUMW'(sq6[2]);

    always_comb begin
        o_q_item.shift = sh6;
        o_q_item.last  = r_last[6];
        if ((|ovf6) || (sum > SUMW'(DIST_MAX))) begin
            o_q_item.dist_sq = DIST_MAX;
        end else begin
            o_q_item.dist_sq = sum[DIST_W-1:0];
        end
    end

    assign o_q_push = r_v[6];

endmodule

// ----- design/misd_queue.sv -----
// small queue between front pipeline and running-min back end
// depends on misd_pkg
`timescale 1ns / 1ps

module misd_queue import misd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output logic    o_valid,
    output t_item   o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_pop;

    // writer never overruns, the front holds credits for every entry
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- design/misd_back.sv -----
// back end: running arg-min over the pair stream and the result register
// depends on misd_pkg
`timescale 1ns / 1ps

module misd_back import misd_pkg::*; #(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_res
);

    localparam int CNT_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_PAIRS - 1);

    logic [DIST_W-1:0]              r_best_dist;
    logic [AXES-1:0][SHIFT_W-1:0]   r_best_shift;
    logic [CNT_W-1:0]               r_best_pos;
    logic [CNT_W-1:0]               r_count;
    logic                           r_valid;
    t_result                        r_res;

    logic                           upd;
    logic [DIST_W-1:0]              nb_dist;
    logic [AXES-1:0][SHIFT_W-1:0]   nb_shift;
    logic [CNT_W-1:0]               nb_pos;
    logic [CNT_W+INDEX_W-1:0]       pos_ext;

    assign o_take  = i_valid && (!r_valid || i_pop);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // first pair of a search always loads, later only a strictly smaller one
    assign upd      = (r_count == '0) || (i_item.dist_sq < r_best_dist);
    assign nb_dist  = upd ? i_item.dist_sq : r_best_dist;
    assign nb_shift = upd ? i_item.shift : r_best_shift;
    assign nb_pos   = upd ? r_count      : r_best_pos;
    assign pos_ext  = {{INDEX_W{1'b0}}, nb_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_best_dist  <= DIST_MAX;
            r_best_shift <= '0;
            r_best_pos   <= '0;
            r_count      <= '0;
        end else begin
            if (o_take) begin
                r_valid <= 1'b1;
                if (i_item.last) begin
                    r_best_dist  <= DIST_MAX;
                    r_best_shift <= '0;
                    r_best_pos   <= '0;
                    r_count      <= '0;
                end else begin
                    r_best_dist  <= nb_dist;
                    r_best_shift <= nb_shift;
                    r_best_pos   <= nb_pos;
                    r_count      <= (r_count == LAST_CNT) ? '0 : r_count + 1'b1;
                end
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res.dist_sq <= i_item.dist_sq;
            if (i_item.last) begin
                r_res.shift   <= nb_shift;
                r_res.index   <= pos_ext[INDEX_W-1:0];
                r_res.is_last <= 1'b1;
            end else begin
                r_res.shift   <= '0;
                r_res.index   <= '0;
                r_res.is_last <= 1'b0;
            end
        end
    end

endmodule
